// File: rtl/core/assert_macros.svh
// assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, masked during reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probe string hash table.
// ----------------------------------------------------------------------------
`default_nettype none
package lpht_pkg;
    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] HASH_MULT = 32'h01000193;
    localparam logic [7:0]  CASE_MASK = 8'hdf;

    typedef enum logic [2:0] {
        FN_FIND = 3'd0, FN_INSERT = 3'd1, FN_REMOVE = 3'd2,
        FN_REMOVE_SLOT = 3'd3, FN_CLEAR = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        MK_EMPTY = 2'd0, MK_USED = 2'd1, MK_GONE = 2'd2, MK_RSVD = 2'd3
    } t_mark;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_FULL = 2'd2, ST_NOT_USED = 2'd3
    } t_status;

    localparam logic CFG_CASE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_READ, S_CHECK, S_WRITE, S_CLEAR, S_SLOT_RD, S_SLOT_CK, S_DONE
    } t_state;

    // hash unit status toward the sequencer
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [30:0] hash;
    } t_hash_stat;

    // fold ascii upper case to lower case per byte
    function automatic logic [63:0] fold_key(input logic [63:0] k);
        logic [63:0] r;
        logic [7:0]  b;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            b = k[8*i +: 8];
            if (b >= 8'h41 && b <= 8'h5a) b = b + 8'h20;
            r[8*i +: 8] = b;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    output logic      [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: rtl/core/lpht_hash.sv
// ----------------------------------------------------------------------------
// lpht_hash
// FNV-1a hash, one character per cycle, stops at the first zero byte.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_hash #(
    parameter int KEY_CHARS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_ci,
    input  wire logic [63:0]          i_key,
    output lpht_pkg::t_hash_stat      o_stat
);
    import lpht_pkg::*;
    localparam int CW = $clog2(KEY_CHARS + 1);

    logic [31:0] r_h, n_h;
    logic [63:0] r_k, n_k;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_busy, n_busy, r_done, n_done;
    logic [7:0]  w_b;
    logic [31:0] w_v;
    logic [31:0] w_x;

    assign w_b = r_k[7:0];
    assign w_v = i_ci ? {24'd0, w_b & CASE_MASK} : {{24{w_b[7]}}, w_b};
    assign w_x = r_h ^ w_v;

    // one round per cycle
    always_comb begin
        n_h = r_h; n_k = r_k; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_h = FNV_BASIS; n_k = i_key; n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_b == 8'd0 || r_cnt == CW'(KEY_CHARS)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end else begin
                n_h = 32'(w_x * HASH_MULT);
                n_k = {8'd0, r_k[63:8]};
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_h <= n_h; r_k <= n_k;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.hash = r_h[30:0];
endmodule
`default_nettype wire

// File: rtl/core/linear_probe_string_hash_table_core.sv
// ----------------------------------------------------------------------------
// linear_probe_string_hash_table_core
// Open-addressed string key table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// sequence: the key is hashed, then each probed slot is read from memory
//   and compared, then any write is made and the result beat is given
// clear walks every slot of the configured size, one per cycle
// throughput: one item at a time, the next beat is taken in the cycle after
//   the result beat is taken
// reset: synchronous; a clearing pass over all TABLE_DEPTH slots marks them
//   empty, no item is taken until it ends
`default_nettype none
module linear_probe_string_hash_table_core #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_CHARS   = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_func,
    input  wire logic [63:0] i_key_bytes,
    input  wire logic [7:0]  i_slot_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_slot_out,
    output logic             o_created,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data
);
    import lpht_pkg::*;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LMAX = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int EW = 2 + 31 + 64;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    logic r_ci;
    logic [3:0] r_lg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci <= 1'b0; r_lg <= 4'd8;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CASE) r_ci <= i_cfg_data[0];
            else r_lg <= i_cfg_data;
        end
    end

    logic [4:0] w_lg;
    logic [AW:0] w_count;
    logic [AW-1:0] w_mask;
    assign w_lg = (32'(r_lg) < LMAX) ? {1'b0, r_lg} : 5'(LMAX);
    assign w_count = (AW+1)'(1) << w_lg;
    assign w_mask = AW'(w_count - 1'b1);

    // request registers
    t_state r_st, n_st;
    t_func r_fn;
    logic [63:0] r_key;
    logic [7:0] r_sin;
    logic [30:0] r_h;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW:0] r_n, n_n;
    logic r_av_ok, n_av_ok;
    logic [AW-1:0] r_av, n_av;
    logic [7:0] r_slot, n_slot;
    logic r_cr, n_cr;
    logic [1:0] r_stat, n_stat;
    logic r_ov, n_ov;

    // trimmed key
    logic [63:0] w_tk;
    always_comb begin
        logic z;
        z = 1'b0; w_tk = '0;
        for (int i = 0; i < KEY_CHARS; i++) begin
            if (i_key_bytes[8*i +: 8] == 8'd0) z = 1'b1;
            if (!z) w_tk[8*i +: 8] = i_key_bytes[8*i +: 8];
        end
    end

    logic w_acc;
    assign o_stall = (r_st != S_IDLE) || r_ov;
    assign w_acc = i_valid && !o_stall;

    t_hash_stat w_hs;
    lpht_hash #(.KEY_CHARS(KEY_CHARS)) u_hash (
        .i_clk, .i_rst_n, .i_start(w_acc && t_func'(i_func) != FN_REMOVE_SLOT),
        .i_ci(r_ci), .i_key(w_tk), .o_stat(w_hs)
    );

    // slot memory: mark, hash, key
    logic w_we;
    logic [AW-1:0] w_addr;
    logic [EW-1:0] w_wd, w_rd;
    lpht_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk, .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wd), .o_rdata(w_rd)
    );
    t_mark w_mk;
    logic [30:0] w_sh;
    logic [63:0] w_sk;
    logic w_match;
    assign w_mk = t_mark'(w_rd[EW-1 -: 2]);
    assign w_sh = w_rd[94:64];
    assign w_sk = w_rd[63:0];
    assign w_match = (w_mk == MK_USED) && (w_sh == r_h) &&
        (r_ci ? (fold_key(w_sk) == fold_key(r_key)) : (w_sk == r_key));

    // next state
    always_comb begin
        n_st = r_st; n_idx = r_idx; n_n = r_n; n_av_ok = r_av_ok; n_av = r_av;
        n_slot = r_slot; n_cr = r_cr; n_stat = r_stat;
        unique case (r_st)
            S_IDLE: if (w_acc) begin
                n_slot = '0; n_cr = 1'b0; n_stat = ST_OK; n_av_ok = 1'b0; n_n = '0;
                n_idx = '0;
                priority case (t_func'(i_func))
                    FN_REMOVE_SLOT: n_st = S_SLOT_RD;
                    FN_CLEAR: n_st = S_CLEAR;
                    FN_FIND, FN_INSERT, FN_REMOVE: n_st = S_HASH;
                    default: n_st = S_DONE;
                endcase
            end
            S_HASH: if (w_hs.done) begin
                n_idx = w_hs.hash[AW-1:0] & w_mask; n_st = S_READ;
            end
            S_READ: n_st = S_CHECK;
            S_CHECK: begin
                if (w_match) begin
                    n_slot = 8'(r_idx);
                    n_st = (r_fn == FN_REMOVE) ? S_WRITE : S_DONE;
                end else if (w_mk != MK_USED && r_fn == FN_INSERT && !r_av_ok) begin
                    n_av_ok = 1'b1; n_av = r_idx;
                end
                if (!w_match) begin
                    if (w_mk == MK_EMPTY || r_n + 1'b1 == w_count) begin
                        if (r_fn == FN_INSERT && (r_av_ok || w_mk != MK_USED)) begin
                            n_slot = 8'(r_av_ok ? r_av : r_idx);
                            n_idx = r_av_ok ? r_av : r_idx;
                            n_cr = 1'b1; n_st = S_WRITE;
                        end else begin
                            n_stat = (r_fn == FN_INSERT) ? ST_FULL : ST_NOT_FOUND;
                            n_st = S_DONE;
                        end
                    end else begin
                        n_n = r_n + 1'b1; n_idx = (r_idx + 1'b1) & w_mask; n_st = S_READ;
                    end
                end
            end
            S_WRITE: n_st = S_DONE;
            S_CLEAR: begin
                n_idx = r_idx + 1'b1;
                if (r_fn == FN_CLEAR) begin
                    if (32'(r_idx) + 1 >= 32'(w_count)) n_st = S_DONE;
                end else if (32'(r_idx) + 1 >= TABLE_DEPTH) begin
                    n_st = S_IDLE;
                end
            end
            S_SLOT_RD: begin
                if (32'(r_sin) >= 32'(w_count)) begin
                    n_stat = ST_NOT_USED; n_st = S_DONE;
                end else begin
                    n_idx = AW'(r_sin); n_st = S_SLOT_CK;
                end
            end
            S_SLOT_CK: if (w_mk == MK_USED) begin
                n_slot = r_sin; n_st = S_WRITE;
            end else begin
                n_stat = ST_NOT_USED; n_st = S_DONE;
            end
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // memory port drive
    always_comb begin
        w_addr = r_idx; w_we = 1'b0; w_wd = {MK_EMPTY, 31'd0, 64'd0};
        if (r_st == S_SLOT_RD) w_addr = AW'(r_sin);
        else if (r_st == S_CLEAR) w_we = 1'b1;
        else if (r_st == S_WRITE) begin
            w_we = 1'b1;
            w_wd = r_cr ? {MK_USED, r_h, r_key} : {MK_GONE, 31'd1, 64'd0};
        end
    end

    always_comb n_ov = (r_ov && i_stall) || (r_st == S_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR; r_idx <= '0; r_ov <= 1'b0; r_fn <= FN_FIND;
        end else begin
            r_st <= n_st; r_idx <= n_idx; r_ov <= n_ov;
            if (w_acc) r_fn <= t_func'(i_func);
        end
        if (w_acc) begin
            r_key <= w_tk; r_sin <= i_slot_in;
        end
        if (w_hs.done) r_h <= w_hs.hash;
        r_n <= n_n; r_av_ok <= n_av_ok; r_av <= n_av;
        r_slot <= n_slot; r_cr <= n_cr; r_stat <= n_stat;
    end

    // the reset sweep covers all slots regardless of size
    assign o_valid = r_ov;
    assign o_slot_out = r_slot;
    assign o_created = r_cr;
    assign o_status = r_stat;
endmodule
`default_nettype wire

// File: rtl/core/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks on the table core, bound into that module.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lpht_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_slot_out,
    input wire logic       o_created,
    input wire logic [1:0] o_status
);
    import lpht_pkg::*;
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_slot_out), "result dropped")
    `CHK_IMPL(a_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_slot_out == 8'd0 && !o_created, "bad slot on error")
    `CHK_IMPL(a_busy, i_clk, i_rst_n, o_valid, o_stall, "accepting while result pending")
    `CHK_NEXT(a_one, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "second item taken")
endmodule

bind linear_probe_string_hash_table_core lpht_checker u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
    .o_slot_out, .o_created, .o_status
);
`default_nettype wire
